### rtl/tlr_pkg.sv
// Shared types and constants of the thick line rasterizer.
package tlr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int IN_BITS     = 16;
    localparam int MAX_BRUSH   = 16;
    localparam int BRUSH_BITS  = 5;
    localparam int BCNT_BITS   = $clog2(MAX_BRUSH);
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int PITCH_BITS  = 15;
    localparam int OFFSET_BITS = 26;
    localparam int COLOR_BITS  = 32;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    localparam logic [1:0] REG_SURFACE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SURFACE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ROW_PITCH      = 2'd2;

    localparam logic [COORD_BITS-1:0] RESET_WIDTH  = COORD_BITS'(640);
    localparam logic [COORD_BITS-1:0] RESET_HEIGHT = COORD_BITS'(480);
    localparam logic [PITCH_BITS-1:0] RESET_PITCH  = PITCH_BITS'(2560);

    typedef struct packed {
        logic                       command;
        logic signed [IN_BITS-1:0]  start_x;
        logic signed [IN_BITS-1:0]  start_y;
        logic signed [IN_BITS-1:0]  end_x;
        logic signed [IN_BITS-1:0]  end_y;
        logic [COLOR_BITS-1:0]      pixel_color;
        logic [BRUSH_BITS-1:0]      brush_size;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  pixel_x;
        logic [COORD_BITS-1:0]  pixel_y;
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [COLOR_BITS-1:0]  write_color;
        logic                   last_pixel;
        logic                   no_pixel;
    } out_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] surface_width;
        logic [COORD_BITS-1:0] surface_height;
        logic [PITCH_BITS-1:0] row_pitch_bytes;
    } cfg_t;

endpackage

### rtl/tlr_stepper.sv
// Line state, Bresenham stepping and brush walk; one pixel per next command.
module tlr_stepper (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  tlr_pkg::in_item_t item,
    input  tlr_pkg::cfg_t     cfg,
    output tlr_pkg::out_item_t result,
    output logic              result_valid
);

    function automatic logic [tlr_pkg::COORD_BITS-1:0] clamp_coord(
        input logic signed [tlr_pkg::IN_BITS-1:0]    p,
        input logic [tlr_pkg::COORD_BITS-1:0]        size,
        input logic [tlr_pkg::BRUSH_BITS-1:0]        brush
    );
        logic [tlr_pkg::COORD_BITS:0]   lim;
        logic [tlr_pkg::COORD_BITS-1:0] lim_sat;
        logic [tlr_pkg::COORD_BITS-1:0] r;
        lim = {1'b0, size}
            - {{(tlr_pkg::COORD_BITS - tlr_pkg::BRUSH_BITS + 1){1'b0}}, brush};
        lim_sat = lim[tlr_pkg::COORD_BITS] ? '0 : lim[tlr_pkg::COORD_BITS-1:0];
        if (p[tlr_pkg::IN_BITS-1])
        begin
            r = '0;
        end
        else if ({1'b0, p[tlr_pkg::IN_BITS-2:0]} >
                 {{(tlr_pkg::IN_BITS - tlr_pkg::COORD_BITS){1'b0}}, lim_sat})
        begin
            r = lim_sat;
        end
        else
        begin
            r = p[tlr_pkg::COORD_BITS-1:0];
        end
        return r;
    endfunction

    logic [tlr_pkg::COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [tlr_pkg::COORD_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic [tlr_pkg::COORD_BITS-1:0] target_x_reg, target_x_next;
    logic [tlr_pkg::COORD_BITS-1:0] target_y_reg, target_y_next;
    logic [tlr_pkg::COORD_BITS-1:0] span_x_reg, span_x_next;
    logic [tlr_pkg::COORD_BITS-1:0] span_y_reg, span_y_next;
    logic                           step_x_neg_reg, step_x_neg_next;
    logic                           step_y_neg_reg, step_y_neg_next;
    logic signed [tlr_pkg::ERR_BITS-1:0] error_reg, error_next;
    logic [tlr_pkg::BCNT_BITS-1:0]  column_reg, column_next;
    logic [tlr_pkg::BCNT_BITS-1:0]  row_reg, row_next;
    logic [tlr_pkg::BRUSH_BITS-1:0] brush_reg, brush_next;
    logic [tlr_pkg::COLOR_BITS-1:0] color_reg, color_next;
    logic                           active_reg, active_next;

    logic [tlr_pkg::BRUSH_BITS-1:0] brush_sat;
    logic [tlr_pkg::COORD_BITS-1:0] cx, cy, tx, ty;
    logic [tlr_pkg::COORD_BITS-1:0] dx, dy;
    logic [tlr_pkg::COORD_BITS-1:0] px, py;
    logic [tlr_pkg::COORD_BITS+tlr_pkg::PITCH_BITS-1:0] row_product;
    logic row_wrap, column_wrap, at_target, move_x, move_y;
    logic signed [tlr_pkg::ERR_BITS-1:0] span_x_ext, span_y_ext;

    always_comb
    begin
        if (item.brush_size == '0)
        begin
            brush_sat = tlr_pkg::BRUSH_BITS'(1);
        end
        else if (item.brush_size > tlr_pkg::BRUSH_BITS'(tlr_pkg::MAX_BRUSH))
        begin
            brush_sat = tlr_pkg::BRUSH_BITS'(tlr_pkg::MAX_BRUSH);
        end
        else
        begin
            brush_sat = item.brush_size;
        end
        cx = clamp_coord(item.start_x, cfg.surface_width, brush_sat);
        cy = clamp_coord(item.start_y, cfg.surface_height, brush_sat);
        tx = clamp_coord(item.end_x, cfg.surface_width, brush_sat);
        ty = clamp_coord(item.end_y, cfg.surface_height, brush_sat);
        dx = (tx >= cx) ? tx - cx : cx - tx;
        dy = (ty >= cy) ? ty - cy : cy - ty;
    end

    // Pixel of the brush square at the current cursor.
    always_comb
    begin
        px = cursor_x_reg + tlr_pkg::COORD_BITS'(column_reg);
        py = cursor_y_reg + tlr_pkg::COORD_BITS'(row_reg);
        row_product = py * cfg.row_pitch_bytes;
        row_wrap    = ({1'b0, row_reg} + tlr_pkg::BRUSH_BITS'(1)) == brush_reg;
        column_wrap = ({1'b0, column_reg} + tlr_pkg::BRUSH_BITS'(1)) == brush_reg;
        at_target   = (cursor_x_reg == target_x_reg) && (cursor_y_reg == target_y_reg);
        span_x_ext  = $signed({2'b00, span_x_reg});
        span_y_ext  = $signed({2'b00, span_y_reg});
        move_x      = error_reg > -span_x_ext;
        move_y      = error_reg < span_y_ext;
    end

    always_comb
    begin
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        span_x_next     = span_x_reg;
        span_y_next     = span_y_reg;
        step_x_neg_next = step_x_neg_reg;
        step_y_neg_next = step_y_neg_reg;
        error_next      = error_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        brush_next      = brush_reg;
        color_next      = color_reg;
        active_next     = active_reg;
        result          = '0;
        result_valid    = 1'b0;

        if (accept && item.command == tlr_pkg::CMD_START)
        begin
            brush_next      = brush_sat;
            color_next      = item.pixel_color;
            cursor_x_next   = cx;
            cursor_y_next   = cy;
            target_x_next   = tx;
            target_y_next   = ty;
            span_x_next     = dx;
            span_y_next     = dy;
            step_x_neg_next = !(cx < tx);
            step_y_neg_next = !(cy < ty);
            // Halving rounds toward zero, so the negative case negates a shift.
            if (dx > dy)
            begin
                error_next = $signed({3'b000, dx[tlr_pkg::COORD_BITS-1:1]});
            end
            else
            begin
                error_next = -$signed({3'b000, dy[tlr_pkg::COORD_BITS-1:1]});
            end
            column_next = '0;
            row_next    = '0;
            active_next = 1'b1;
        end
        else if (accept)
        begin
            result_valid = 1'b1;
            if (!active_reg)
            begin
                result.no_pixel = 1'b1;
            end
            else
            begin
                result.pixel_x     = px;
                result.pixel_y     = py;
                result.byte_offset = tlr_pkg::OFFSET_BITS'(row_product)
                                   + tlr_pkg::OFFSET_BITS'({px, 2'b00});
                result.write_color = color_reg;
                row_next = row_reg + tlr_pkg::BCNT_BITS'(1);
                if (row_wrap)
                begin
                    row_next    = '0;
                    column_next = column_reg + tlr_pkg::BCNT_BITS'(1);
                    if (column_wrap)
                    begin
                        column_next = '0;
                        if (at_target)
                        begin
                            result.last_pixel = 1'b1;
                            active_next       = 1'b0;
                        end
                        else
                        begin
                            error_next = error_reg
                                       - (move_x ? span_y_ext : '0)
                                       + (move_y ? span_x_ext : '0);
                            if (move_x)
                            begin
                                cursor_x_next = step_x_neg_reg
                                    ? cursor_x_reg - tlr_pkg::COORD_BITS'(1)
                                    : cursor_x_reg + tlr_pkg::COORD_BITS'(1);
                            end
                            if (move_y)
                            begin
                                cursor_y_next = step_y_neg_reg
                                    ? cursor_y_reg - tlr_pkg::COORD_BITS'(1)
                                    : cursor_y_reg + tlr_pkg::COORD_BITS'(1);
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            target_x_reg   <= '0;
            target_y_reg   <= '0;
            span_x_reg     <= '0;
            span_y_reg     <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            error_reg      <= '0;
            column_reg     <= '0;
            row_reg        <= '0;
            brush_reg      <= tlr_pkg::BRUSH_BITS'(1);
            color_reg      <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            target_x_reg   <= target_x_next;
            target_y_reg   <= target_y_next;
            span_x_reg     <= span_x_next;
            span_y_reg     <= span_y_next;
            step_x_neg_reg <= step_x_neg_next;
            step_y_neg_reg <= step_y_neg_next;
            error_reg      <= error_next;
            column_reg     <= column_next;
            row_reg        <= row_next;
            brush_reg      <= brush_next;
            color_reg      <= color_next;
            active_reg     <= active_next;
        end
    end

endmodule

### rtl/thick_line_rasterizer.sv
// Top level of the thick line rasterizer: register port, stepper and output buffer.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------
//   cmd     | in        | cmd_valid/cmd_stall | tlr_pkg::in_item_t
//   pix     | out       | pix_valid/pix_stall | tlr_pkg::out_item_t
//   apb     | in/out    | psel/penable/pready | paddr, pwdata, prdata
//
// One command item is taken every cycle while cmd_stall is low; a next command's
// pixel is registered in the output or skid entry; a start command gives no item.
// The output register plus one skid entry absorb a stall; cmd_stall rises only
// while the skid entry is occupied. Reset clears the line state to idle and
// loads the default surface geometry.
module thick_line_rasterizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tlr_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [tlr_pkg::DATA_BITS-1:0]  pwdata,
    output logic [tlr_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  tlr_pkg::in_item_t              cmd,
    output logic                           pix_valid,
    input  logic                           pix_stall,
    output tlr_pkg::out_item_t             pix
);

    tlr_pkg::cfg_t      cfg_reg, cfg_next;
    tlr_pkg::out_item_t out_item_reg, out_item_next;
    tlr_pkg::out_item_t skid_item_reg, skid_item_next;
    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;

    tlr_pkg::out_item_t result;
    logic               result_valid;
    logic               accept;
    logic               out_fire;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cmd_stall = skid_valid_reg;
    assign accept    = cmd_valid && !skid_valid_reg;
    assign pix_valid = out_valid_reg;
    assign pix       = out_item_reg;
    assign out_fire  = out_valid_reg && !pix_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                tlr_pkg::REG_SURFACE_WIDTH:
                    cfg_next.surface_width = pwdata[tlr_pkg::COORD_BITS-1:0];
                tlr_pkg::REG_SURFACE_HEIGHT:
                    cfg_next.surface_height = pwdata[tlr_pkg::COORD_BITS-1:0];
                tlr_pkg::REG_ROW_PITCH:
                    cfg_next.row_pitch_bytes = pwdata[tlr_pkg::PITCH_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            tlr_pkg::REG_SURFACE_WIDTH:
                prdata = tlr_pkg::DATA_BITS'(cfg_reg.surface_width);
            tlr_pkg::REG_SURFACE_HEIGHT:
                prdata = tlr_pkg::DATA_BITS'(cfg_reg.surface_height);
            tlr_pkg::REG_ROW_PITCH:
                prdata = tlr_pkg::DATA_BITS'(cfg_reg.row_pitch_bytes);
            default:
                prdata = '0;
        endcase
    end

    tlr_stepper u_stepper (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (cmd),
        .cfg          (cfg_reg),
        .result       (result),
        .result_valid (result_valid)
    );

    // A new pixel goes straight to the output register when it is free or
    // draining this cycle, and into the skid entry otherwise.
    always_comb
    begin
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (result_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_item_next  = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_item_next  = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.surface_width   <= tlr_pkg::RESET_WIDTH;
            cfg_reg.surface_height  <= tlr_pkg::RESET_HEIGHT;
            cfg_reg.row_pitch_bytes <= tlr_pkg::RESET_PITCH;
            out_valid_reg           <= 1'b0;
            skid_valid_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

endmodule
